/* src/chat_pkg.sv */
`default_nettype none
package chat_pkg;

	localparam int ANG_FRAC  = 16;
	localparam int PRESHIFT  = 24;
	localparam int TABLE_LEN = 24;
	localparam int ANG_W     = 25;
	localparam int ATAN_W    = 23;

	localparam logic [ANG_W-1:0] DEG_90  = ANG_W'(90  << ANG_FRAC);
	localparam logic [ANG_W-1:0] DEG_180 = ANG_W'(180 << ANG_FRAC);
	localparam logic [ANG_W-1:0] DEG_360 = ANG_W'(360 << ANG_FRAC);

	localparam int HOUR_DEG   = 360 / 12;
	localparam int MINUTE_DEG = 360 / 60;

	typedef struct packed {
		logic vld;
		logic tag;
		logic dot_neg;
		logic crs_neg;
		logic x_zero;
		logic y_zero;
	} chat_flags_t;

	// atan(2^-i) in 2^-16 degree
	function automatic logic [ATAN_W-1:0] atan_at(input int unsigned i);
		logic [ATAN_W-1:0] v;
		case (i)
			0:  v = 23'd2949120;
			1:  v = 23'd1740967;
			2:  v = 23'd919879;
			3:  v = 23'd466945;
			4:  v = 23'd234379;
			5:  v = 23'd117304;
			6:  v = 23'd58666;
			7:  v = 23'd29335;
			8:  v = 23'd14668;
			9:  v = 23'd7334;
			10: v = 23'd3667;
			11: v = 23'd1833;
			12: v = 23'd917;
			13: v = 23'd458;
			14: v = 23'd229;
			15: v = 23'd115;
			16: v = 23'd57;
			17: v = 23'd29;
			18: v = 23'd14;
			19: v = 23'd7;
			20: v = 23'd4;
			21: v = 23'd2;
			22: v = 23'd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

/* src/chat_cordic_stage.sv */
`default_nettype none
module chat_cordic_stage #(
	parameter int XW   = 52,
	parameter int ZW   = 26,
	parameter int STEP = 0
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     en,
	input  wire chat_pkg::chat_flags_t flags_in,
	input  wire  signed [XW-1:0]    x_in,
	input  wire  signed [XW-1:0]    y_in,
	input  wire  signed [ZW-1:0]    z_in,
	output chat_pkg::chat_flags_t   flags_out,
	output logic signed [XW-1:0]    x_out,
	output logic signed [XW-1:0]    y_out,
	output logic signed [ZW-1:0]    z_out
);
	import chat_pkg::*;

	localparam logic signed [ZW-1:0] ATAN = ZW'(atan_at(STEP));

	logic signed [XW-1:0] xs, ys;

	assign xs = x_in >>> STEP;
	assign ys = y_in >>> STEP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_out <= '0;
		end else if (en) begin
			flags_out <= flags_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!y_in[XW-1]) begin
				x_out <= x_in + ys;
				y_out <= y_in - xs;
				z_out <= z_in + ATAN;
			end else begin
				x_out <= x_in - ys;
				y_out <= y_in + xs;
				z_out <= z_in - ATAN;
			end
		end
	end

endmodule
`default_nettype wire

/* src/chat_lane.sv */
`default_nettype none
module chat_lane #(
	parameter int COORD_BITS   = 12,
	parameter int FRAC_BITS    = 8,
	parameter int CORDIC_STEPS = 16,
	parameter int DEG          = 30,
	parameter int OW           = 12
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          en,
	input  wire chat_pkg::chat_flags_t   flags_in,
	input  wire  signed [COORD_BITS:0]   tx,
	input  wire  signed [COORD_BITS:0]   ty,
	input  wire  signed [COORD_BITS:0]   px,
	input  wire  signed [COORD_BITS:0]   py,
	output chat_pkg::chat_flags_t        flags_out,
	output logic        [OW-1:0]         res
);
	import chat_pkg::*;

	localparam int PW = 2 * COORD_BITS + 3;
	localparam int AW = 2 * COORD_BITS + 1;
	localparam int XW = AW + PRESHIFT + 3;
	localparam int ZW = 26;
	localparam int NW = ANG_W + FRAC_BITS + 1;
	localparam int VW = NW - ANG_FRAC;
	localparam int K  = VW + 5;
	localparam longint unsigned RECIP = (64'd1 << K) / DEG;
	localparam logic [K-1:0] RECIP_C = RECIP[K-1:0];
	localparam logic [NW-1:0] HALF = NW'((DEG << ANG_FRAC) / 2);
	localparam logic [VW-1:0] DEG_V = VW'(DEG);

	// products
	logic signed [PW-1:0] dot_s2, crs_s2;
	chat_flags_t f_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_s2 <= '0;
		end else if (en) begin
			f_s2 <= flags_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dot_s2 <= PW'(tx) * PW'(px) + PW'(ty) * PW'(py);
			crs_s2 <= PW'(ty) * PW'(px) - PW'(tx) * PW'(py);
		end
	end

	// magnitudes and CORDIC seed
	logic [PW-1:0] dot_abs, crs_abs;
	logic signed [XW-1:0] x_s3, y_s3;
	chat_flags_t f_s3, f_seed;

	assign dot_abs = dot_s2[PW-1] ? PW'(-dot_s2) : PW'(dot_s2);
	assign crs_abs = crs_s2[PW-1] ? PW'(-crs_s2) : PW'(crs_s2);

	always_comb begin
		f_seed = f_s2;
		f_seed.dot_neg = dot_s2[PW-1];
		f_seed.crs_neg = crs_s2[PW-1];
		f_seed.x_zero  = (dot_s2 == '0);
		f_seed.y_zero  = (crs_s2 == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_s3 <= '0;
		end else if (en) begin
			f_s3 <= f_seed;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s3 <= $signed(XW'({dot_abs[AW-1:0], {PRESHIFT{1'b0}}}));
			y_s3 <= $signed(XW'({crs_abs[AW-1:0], {PRESHIFT{1'b0}}}));
		end
	end

	// CORDIC chain
	logic signed [XW-1:0] xc [CORDIC_STEPS+1];
	logic signed [XW-1:0] yc [CORDIC_STEPS+1];
	logic signed [ZW-1:0] zc [CORDIC_STEPS+1];
	chat_flags_t fc [CORDIC_STEPS+1];

	assign xc[0] = x_s3;
	assign yc[0] = y_s3;
	assign zc[0] = '0;
	assign fc[0] = f_s3;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		chat_cordic_stage #(
			.XW   (XW),
			.ZW   (ZW),
			.STEP (i)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.flags_in  (fc[i]),
			.x_in      (xc[i]),
			.y_in      (yc[i]),
			.z_in      (zc[i]),
			.flags_out (fc[i+1]),
			.x_out     (xc[i+1]),
			.y_out     (yc[i+1]),
			.z_out     (zc[i+1])
		);
	end

	// quadrant and side
	logic signed [ZW-1:0] z_end;
	logic [ANG_W-1:0] q_ang, a_half, a_full, ang_s4;
	chat_flags_t f_end, f_s4;

	assign z_end = zc[CORDIC_STEPS];
	assign f_end = fc[CORDIC_STEPS];

	always_comb begin
		if (f_end.y_zero) begin
			q_ang = '0;
		end else if (f_end.x_zero) begin
			q_ang = DEG_90;
		end else if (z_end[ZW-1]) begin
			q_ang = '0;
		end else if (z_end > $signed(ZW'(DEG_90))) begin
			q_ang = DEG_90;
		end else begin
			q_ang = z_end[ANG_W-1:0];
		end
		a_half = f_end.dot_neg ? DEG_180 - q_ang : q_ang;
		a_full = f_end.crs_neg ? DEG_360 - a_half : a_half;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_s4 <= '0;
		end else if (en) begin
			f_s4 <= f_end;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s4 <= a_full;
		end
	end

	// divide by DEG: reciprocal multiply, then one correction
	logic [NW-1:0] num;
	logic [VW-1:0] v_in, v_s5, q_s5, rem;
	logic [VW+K-1:0] prod;
	chat_flags_t f_s5, f_s6;
	logic [VW-1:0] q_s6;

	assign num  = (NW'(ang_s4) << FRAC_BITS) + HALF;
	assign v_in = num[NW-1:ANG_FRAC];
	assign prod = (VW+K)'(v_in) * (VW+K)'(RECIP_C);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_s5 <= '0;
			f_s6 <= '0;
		end else if (en) begin
			f_s5 <= f_s4;
			f_s6 <= f_s5;
		end
	end

	assign rem = v_s5 - VW'(q_s5 * DEG_V);

	always_ff @(posedge clk) begin
		if (en) begin
			v_s5 <= v_in;
			q_s5 <= prod[VW+K-1:K];
			q_s6 <= (rem >= DEG_V) ? q_s5 + VW'(1) : q_s5;
		end
	end

	assign flags_out = f_s6;
	assign res       = q_s6[OW-1:0];

endmodule
`default_nettype wire

/* src/clock_hand_angle_to_time.sv */
`default_nettype none
// channel | valid        | ready        | payload
// item    | item_valid   | item_ready   | center_x/y, top_x/y, minute_tip_x/y, hour_tip_x/y
// result  | result_valid | result_ready | hour_q8, minute_q8, degenerate
//
// One transaction per cycle sustained while the output register is empty or taken;
// stages are input diff, products, seed, one stage per CORDIC step, angle fix,
// reciprocal multiply, correction, output register.
// Two lanes (hour, minute) run in lockstep; the whole pipe holds while the
// output register is full and not taken. Reset clears the flag registers only.
module clock_hand_angle_to_time #(
	parameter int COORD_BITS   = 12,
	parameter int FRAC_BITS    = 8,
	parameter int CORDIC_STEPS = 16
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     item_valid,
	output logic                    item_ready,
	input  wire  [COORD_BITS-1:0]   center_x,
	input  wire  [COORD_BITS-1:0]   center_y,
	input  wire  [COORD_BITS-1:0]   top_x,
	input  wire  [COORD_BITS-1:0]   top_y,
	input  wire  [COORD_BITS-1:0]   minute_tip_x,
	input  wire  [COORD_BITS-1:0]   minute_tip_y,
	input  wire  [COORD_BITS-1:0]   hour_tip_x,
	input  wire  [COORD_BITS-1:0]   hour_tip_y,
	output logic                    result_valid,
	input  wire                     result_ready,
	output logic [FRAC_BITS+3:0]    hour_q8,
	output logic [FRAC_BITS+5:0]    minute_q8,
	output logic                    degenerate
);
	import chat_pkg::*;

	localparam int DW  = COORD_BITS + 1;
	localparam int HW  = FRAC_BITS + 4;
	localparam int MW  = FRAC_BITS + 6;

	logic en;
	assign en         = !result_valid || result_ready;
	assign item_ready = en;

	logic signed [DW-1:0] d_tx, d_ty, d_mx, d_my, d_hx, d_hy;
	logic signed [DW-1:0] tx_s1, ty_s1, mx_s1, my_s1, hx_s1, hy_s1;
	chat_flags_t f_s1;

	assign d_tx = $signed({1'b0, top_x})        - $signed({1'b0, center_x});
	assign d_ty = $signed({1'b0, center_y})     - $signed({1'b0, top_y});
	assign d_mx = $signed({1'b0, minute_tip_x}) - $signed({1'b0, center_x});
	assign d_my = $signed({1'b0, center_y})     - $signed({1'b0, minute_tip_y});
	assign d_hx = $signed({1'b0, hour_tip_x})   - $signed({1'b0, center_x});
	assign d_hy = $signed({1'b0, center_y})     - $signed({1'b0, hour_tip_y});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_s1 <= '0;
		end else if (en) begin
			f_s1 <= '{vld: item_valid,
				tag: (d_tx == '0 && d_ty == '0) || (d_mx == '0 && d_my == '0) ||
					(d_hx == '0 && d_hy == '0),
				default: 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tx_s1 <= d_tx;
			ty_s1 <= d_ty;
			mx_s1 <= d_mx;
			my_s1 <= d_my;
			hx_s1 <= d_hx;
			hy_s1 <= d_hy;
		end
	end

	chat_flags_t f_hour, f_min;
	logic [HW-1:0] hour_res;
	logic [MW-1:0] min_res;

	chat_lane #(
		.COORD_BITS   (COORD_BITS),
		.FRAC_BITS    (FRAC_BITS),
		.CORDIC_STEPS (CORDIC_STEPS),
		.DEG          (HOUR_DEG),
		.OW           (HW)
	) u_hour (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.flags_in  (f_s1),
		.tx        (tx_s1),
		.ty        (ty_s1),
		.px        (hx_s1),
		.py        (hy_s1),
		.flags_out (f_hour),
		.res       (hour_res)
	);

	chat_lane #(
		.COORD_BITS   (COORD_BITS),
		.FRAC_BITS    (FRAC_BITS),
		.CORDIC_STEPS (CORDIC_STEPS),
		.DEG          (MINUTE_DEG),
		.OW           (MW)
	) u_minute (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.flags_in  (f_s1),
		.tx        (tx_s1),
		.ty        (ty_s1),
		.px        (mx_s1),
		.py        (my_s1),
		.flags_out (f_min),
		.res       (min_res)
	);

	// merge
	logic degen;
	assign degen = f_hour.tag || f_min.tag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (en) begin
			result_valid <= f_hour.vld && f_min.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hour_q8    <= degen ? '0 : hour_res;
			minute_q8  <= degen ? '0 : min_res;
			degenerate <= degen;
		end
	end

endmodule
`default_nettype wire
